// ===== design/ssd_pkg.sv =====
// Package: shared types, constants and segment tables for the seven-segment shift driver.
`default_nettype none

package ssd_pkg;

  // Default number of bits shifted per word
  localparam int unsigned SHIFT_BITS_DEF = 32;

  // Width of the segment word built by the front end
  localparam int unsigned SEG_W = 32;

  // Reciprocal multiply for division by ten, exact for any 16-bit value
  localparam logic [16:0] DIV10_MUL = 17'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  // Command codes
  localparam logic CMD_DECIMAL = 1'b0;
  localparam logic CMD_RAW     = 1'b1;

  // Input word
  typedef struct packed {
    logic        command;
    logic [15:0] display_value;
    logic [31:0] raw_word;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic serial_data;
    logic shift_strobe;
    logic latch_strobe;
    logic last;
  } out_word_t;

  // Front end states
  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } fe_state_t;

  // Half-word code for hundreds and units digits (layout PCDE--------GFAB)
  function automatic logic [15:0] half_code(input logic [3:0] d);
    logic [15:0] c;
    case (d)
      4'd0:    c = 16'h7007;
      4'd1:    c = 16'h4001;
      4'd2:    c = 16'h300B;
      4'd3:    c = 16'h600B;
      4'd4:    c = 16'h400D;
      4'd5:    c = 16'h600E;
      4'd6:    c = 16'h700E;
      4'd7:    c = 16'h4003;
      4'd8:    c = 16'h700F;
      4'd9:    c = 16'h600F;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  // Tens digit code at bits 4..11 with decimal point lit
  function automatic logic [15:0] tens_code(input logic [3:0] d);
    logic [15:0] c;
    case (d)
      4'd0:    c = 16'h0F70;
      4'd1:    c = 16'h0C10;
      4'd2:    c = 16'h0BB0;
      4'd3:    c = 16'h0EB0;
      4'd4:    c = 16'h0CD0;
      4'd5:    c = 16'h0EE0;
      4'd6:    c = 16'h0FE0;
      4'd7:    c = 16'h0C30;
      4'd8:    c = 16'h0FF0;
      4'd9:    c = 16'h0EF0;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/seven_segment_shift_driver.sv =====
// Top level: seven-segment shift-register driver (front end, word queue, back end).
// Each word gives SHIFT_BITS+1 results (33 by default): SHIFT_BITS shift bits, then a latch.
// The back end gives one result per cycle unless out_ready stalls it, SHIFT_BITS+1 per word.
// Raw words go via push state and queue; decimal words first take three divide-by-ten steps.
// A new word is taken while the previous one is still shifting; the queue holds two words.
// Reset is synchronous, active high, and empties the front end, queue and sequencer.
`default_nettype none

module seven_segment_shift_driver #(
  parameter int unsigned SHIFT_BITS = ssd_pkg::SHIFT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ssd_pkg::in_word_t  in_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ssd_pkg::out_word_t     out_word
);
  import ssd_pkg::*;

  logic        f_valid;
  logic        f_ready;
  logic [31:0] f_data;
  logic        b_valid;
  logic        b_ready;
  logic [31:0] b_data;

  // Classify and build segment words
  ssd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data)
  );

  // Decouple the two ends
  ssd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  // Serialize
  ssd_back #(
    .SHIFT_BITS (SHIFT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== design/ssd_front.sv =====
// Front end: accepts words, splits decimal values into digits, builds segment words.
`default_nettype none

module ssd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ssd_pkg::in_word_t in_word,
  output logic                  push_valid,
  input  wire logic             push_ready,
  output logic [31:0]           push_data
);
  import ssd_pkg::*;

  fe_state_t   state, state_next;
  logic [1:0]  step;
  logic [15:0] val;
  logic [3:0]  unit_d;
  logic [3:0]  tens_d;
  logic [31:0] word;

  logic [32:0] prod;
  logic [12:0] quot;
  logic [15:0] ten_q;
  logic [15:0] rem_full;
  logic [3:0]  digit;
  logic        accept;

  // One division by ten per cycle
  always_comb begin
    prod     = val * DIV10_MUL;
    quot     = prod[DIV10_SHIFT+12:DIV10_SHIFT];
    ten_q    = {quot, 3'b000} + {2'b00, quot, 1'b0};
    rem_full = val - ten_q;
    digit    = rem_full[3:0];
  end

  // Next state and handshakes
  always_comb begin
    state_next = state;
    push_valid = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      FE_IDLE: begin
        in_ready = 1'b1;
      end
      FE_DIV: begin
        if (step == 2'd2) begin
          state_next = FE_PUSH;
        end
      end
      FE_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          in_ready   = 1'b1;
          state_next = FE_IDLE;
        end
      end
      default: state_next = FE_IDLE;
    endcase
    accept = in_valid && in_ready;
    if (accept) begin
      state_next = (in_word.command == CMD_RAW) ? FE_PUSH : FE_DIV;
    end
  end

  assign push_data = word;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Digit extraction and word assembly
  always_ff @(posedge clk) begin
    if (accept) begin
      val  <= in_word.display_value;
      step <= 2'd0;
      word <= in_word.raw_word;
    end else if (state == FE_DIV) begin
      val  <= {3'b000, quot};
      step <= step + 2'd1;
      case (step)
        2'd0:    unit_d <= digit;
        2'd1:    tens_d <= digit;
        default: word <= {half_code(digit), 16'h0000}
                         | {16'h0000, tens_code(tens_d)}
                         | {16'h0000, half_code(unit_d)}
                         | 32'h0000_0001;
      endcase
    end
  end

  // Checks
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == FE_DIV |-> step != 2'd3)
    else $error("front: digit step out of range");
  a_push_only_ready: assert property (@(posedge clk) disable iff (rst)
    push_valid && !push_ready |=> push_valid && $stable(push_data))
    else $error("front: pending word dropped or changed");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == FE_DIV |-> !in_ready)
    else $error("front: ready while converting");

endmodule

`default_nettype wire

// ===== design/ssd_queue.sv =====
// Two-entry queue of segment words between front and back ends.
`default_nettype none

module ssd_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push_valid,
  output logic             push_ready,
  input  wire logic [31:0] push_data,
  output logic             pop_valid,
  input  wire logic        pop_ready,
  output logic [31:0]      pop_data
);
  import ssd_pkg::*;

  logic [31:0] entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  always_comb begin
    push_ready = (count != 2'd2);
    pop_valid  = (count != 2'd0);
    pop_data   = entry[rd_ptr];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue: count overflow");
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue: pointers disagree with count");
  a_ptr_one: assert property (@(posedge clk) disable iff (rst)
    count == 2'd1 |-> wr_ptr != rd_ptr)
    else $error("queue: pointers disagree with single entry");

endmodule

`default_nettype wire

// ===== design/ssd_back.sv =====
// Back end: shifts each segment word out bit by bit, then issues the latch pulse.
`default_nettype none

module ssd_back #(
  parameter int unsigned SHIFT_BITS = ssd_pkg::SHIFT_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         pop_valid,
  output logic              pop_ready,
  input  wire logic [31:0]  pop_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output ssd_pkg::out_word_t out_word
);
  import ssd_pkg::*;

  localparam int unsigned CW = $clog2(SHIFT_BITS + 1);

  logic          active;
  logic [CW-1:0] cnt;
  logic [31:0]   sh;
  logic          slot_free;
  logic          adv;
  logic          at_latch;

  always_comb begin
    slot_free = !out_valid || out_ready;
    adv       = slot_free && (active || pop_valid);
    pop_ready = slot_free && !active;
    at_latch  = (cnt == CW'(SHIFT_BITS));
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (slot_free) out_valid <= active || pop_valid;
      if (adv) begin
        if (!active) begin
          active <= 1'b1;
          cnt    <= CW'(1);
        end else if (at_latch) begin
          active <= 1'b0;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

  // Shift register and output word
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!active) begin
        sh       <= {1'b0, pop_data[31:1]};
        out_word <= '{serial_data: pop_data[0], shift_strobe: 1'b1,
                      latch_strobe: 1'b0, last: 1'b0};
      end else if (at_latch) begin
        out_word <= '{serial_data: 1'b0, shift_strobe: 1'b0,
                      latch_strobe: 1'b1, last: 1'b1};
      end else begin
        sh       <= {1'b0, sh[31:1]};
        out_word <= '{serial_data: sh[0], shift_strobe: 1'b1,
                      latch_strobe: 1'b0, last: 1'b0};
      end
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    active |-> cnt != '0 && cnt <= CW'(SHIFT_BITS))
    else $error("back: bit count out of range");
  a_latch_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.shift_strobe != out_word.latch_strobe)
    else $error("back: shift and latch together");
  a_latch_ends: assert property (@(posedge clk) disable iff (rst)
    adv && active && at_latch |=> !active)
    else $error("back: sequence did not end after latch");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    active |-> !pop_ready)
    else $error("back: taking a word mid-sequence");

endmodule

`default_nettype wire
